/* rtl/core/global_motion_block_search_macros.svh */
// assertion macros for the global motion block search
`ifndef GLOBAL_MOTION_BLOCK_SEARCH_MACROS_SVH
`define GLOBAL_MOTION_BLOCK_SEARCH_MACROS_SVH
`ifndef ASSERT_OFF
`define GMB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GMB_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) else $error(msg);
`else
`define GMB_ASSERT(label, clk, rst_n, prop, msg)
`define GMB_ASSERT_IMP(label, clk, rst_n, cond, cons, msg)
`endif
`endif

/* rtl/core/gmbs_pkg.sv */
// shared types and constants for the global motion block search
`default_nettype none
package gmbs_pkg;
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DIV,
        ST_SCAN,
        ST_DRAIN,
        ST_COMPARE,
        ST_OUT
    } state_t;

    localparam logic [0:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_FRAME_HEIGHT = 1'b1;
    localparam int unsigned PIXEL_W = 8;
    localparam int unsigned ERR_W   = 16;
    localparam int unsigned SUM_W   = 34;
    localparam int unsigned COUNT_W = 17;
endpackage
`default_nettype wire

/* rtl/core/gmbs_ram.sv */
// generic single port write, single port registered read ram
`default_nettype none
module gmbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/core/global_motion_block_search.sv */
// top level of the global motion block search
// Pixel pairs load one per cycle into two frame memories. The transaction
// marked last starts a full search. Each shift walks every position of the
// w x h frame one per cycle and reads the overlapping pixels through the
// memory read ports and the read pipeline. It then drains that pipeline
// into the sum, and a bit-serial divider forms the mean. The divider is
// skipped when no pixels overlap. A compare state follows. After the last
// shift the result waits for out_ready, and in_ready stays low from the
// last pixel until the result is taken.
`default_nettype none
`include "global_motion_block_search_macros.svh"
module global_motion_block_search #(
    parameter int SEARCH_RANGE = 2,
    parameter int MAX_WIDTH    = 32,
    parameter int MAX_HEIGHT   = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [0:0] cfg_index,
    input  wire logic [5:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] cur_pixel,
    input  wire logic [7:0] prev_pixel,
    input  wire logic       last_pixel,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      move_x,
    output logic [2:0]      move_y,
    output logic [15:0]     min_error
);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 1);
    localparam int SW    = $clog2(2 * SEARCH_RANGE + 1) + 1;
    localparam int DW    = $clog2(2 * SEARCH_RANGE * SEARCH_RANGE + 1);
    localparam int SUM_W = gmbs_pkg::SUM_W;
    localparam int CW    = gmbs_pkg::COUNT_W;
    localparam int QC    = $clog2(SUM_W + 1);

    gmbs_pkg::state_t state_reg, state_next;

    logic [5:0]    fw_reg, fh_reg;
    logic [AW-1:0] load_reg, load_next;
    logic [XW-1:0] w, x_reg, x_next;
    logic [YW-1:0] h, y_reg, y_next;
    logic signed [SW-1:0] dx_reg, dx_next, dy_reg, dy_next;

    // clamp the sizes in use
    always_comb
    begin
        if (fw_reg == 6'd0)
            w = XW'(1);
        else if (32'(fw_reg) > MAX_WIDTH)
            w = XW'(MAX_WIDTH);
        else
            w = XW'(fw_reg);
        if (fh_reg == 6'd0)
            h = YW'(1);
        else if (32'(fh_reg) > MAX_HEIGHT)
            h = YW'(MAX_HEIGHT);
        else
            h = YW'(fh_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= 6'd20;
            fh_reg <= 6'd15;
        end
        else if (cfg_we)
        begin
            if (cfg_index == gmbs_pkg::CFG_FRAME_WIDTH)
                fw_reg <= cfg_data;
            else
                fh_reg <= cfg_data;
        end
    end

    // scan address pair for current position
    logic signed [XW+SW:0] x2;
    logic signed [YW+SW:0] y2;
    logic                  in_ov;
    logic [AW-1:0]         cur_addr, prev_addr, waddr;
    logic                  accept, we;

    assign x2 = $signed({1'b0, x_reg}) + (XW+SW+1)'(dx_reg);
    assign y2 = $signed({1'b0, y_reg}) + (YW+SW+1)'(dy_reg);
    assign in_ov = (x2 >= 0) && (x2 < $signed({1'b0, w})) &&
                   (y2 >= 0) && (y2 < $signed({1'b0, h}));
    assign cur_addr  = AW'(y_reg * w + x_reg);
    assign prev_addr = AW'(y2[YW-1:0] * w + x2[XW-1:0]);
    assign accept = in_valid && in_ready;
    assign we     = accept;
    assign waddr  = load_reg;

    logic [7:0] cur_q, prev_q;
    gmbs_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_cur (
        .clk(clk), .we(we), .waddr(waddr), .wdata(cur_pixel),
        .raddr(cur_addr), .rdata(cur_q));
    gmbs_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_prev (
        .clk(clk), .we(we), .waddr(waddr), .wdata(prev_pixel),
        .raddr(prev_addr), .rdata(prev_q));

    // read pipeline: address stage, data stage, square stage
    logic rv1_reg, rv2_reg, rv3_reg;
    logic signed [8:0] d_reg;
    logic [15:0] sq_reg;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic scan_issue;

    assign scan_issue = (state_reg == gmbs_pkg::ST_SCAN) && in_ov;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv1_reg <= 1'b0;
            rv2_reg <= 1'b0;
            rv3_reg <= 1'b0;
        end
        else
        begin
            rv1_reg <= scan_issue;
            rv2_reg <= rv1_reg;
            rv3_reg <= rv2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg  <= $signed({1'b0, cur_q}) - $signed({1'b0, prev_q});
        sq_reg <= 16'(d_reg * d_reg);
    end

    // divider and best tracking
    localparam int ERR_W_L = gmbs_pkg::ERR_W;
    logic [SUM_W-1:0] quo_reg, quo_next, rem_reg, rem_next;
    logic [SUM_W:0]   trial;
    logic [QC-1:0]    qc_reg, qc_next;
    logic             have_reg, have_next;
    logic [ERR_W_L-1:0] best_err_reg, best_err_next;
    logic signed [SW-1:0] bx_reg, bx_next, by_reg, by_next;
    logic [DW-1:0] bd_reg, bd_next, shift_dist;
    logic [SUM_W-1:0] mean_full;
    logic last_shift, last_pos;

    assign trial = {rem_reg, quo_reg[SUM_W-1]} - {1'b0, (SUM_W-CW)'(0), cnt_reg};
    assign shift_dist = DW'(dx_reg * dx_reg + dy_reg * dy_reg);
    assign mean_full = quo_reg;
    assign last_shift = (dx_reg == SW'(SEARCH_RANGE)) && (dy_reg == SW'(SEARCH_RANGE));
    assign last_pos = (x_reg == w - XW'(1)) && (y_reg == h - YW'(1));

    always_comb
    begin
        state_next    = state_reg;
        load_next     = load_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        qc_next       = qc_reg;
        have_next     = have_reg;
        best_err_next = best_err_reg;
        bx_next       = bx_reg;
        by_next       = by_reg;
        bd_next       = bd_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        if (rv3_reg)
        begin
            sum_next = sum_reg + SUM_W'(sq_reg);
            cnt_next = cnt_reg + CW'(1);
        end
        unique case (state_reg)
            gmbs_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    load_next = (32'(load_reg) == DEPTH - 1) ? '0 : load_reg + AW'(1);
                    if (last_pixel)
                    begin
                        load_next  = '0;
                        state_next = gmbs_pkg::ST_SCAN;
                        x_next     = '0;
                        y_next     = '0;
                        dx_next    = -SW'(SEARCH_RANGE);
                        dy_next    = -SW'(SEARCH_RANGE);
                        sum_next   = '0;
                        cnt_next   = '0;
                        have_next  = 1'b0;
                    end
                end
            end
            gmbs_pkg::ST_SCAN:
            begin
                if (last_pos)
                begin
                    state_next = gmbs_pkg::ST_DRAIN;
                    qc_next    = '0;
                end
                else if (x_reg == w - XW'(1))
                begin
                    x_next = '0;
                    y_next = y_reg + YW'(1);
                end
                else
                begin
                    x_next = x_reg + XW'(1);
                end
            end
            gmbs_pkg::ST_DRAIN:
            begin
                // wait until pipeline empties into the sum
                qc_next = qc_reg + QC'(1);
                if (qc_reg == QC'(3))
                begin
                    quo_next = sum_reg;
                    rem_next = '0;
                    qc_next  = '0;
                    state_next = (cnt_reg == '0) ? gmbs_pkg::ST_COMPARE : gmbs_pkg::ST_DIV;
                end
            end
            gmbs_pkg::ST_DIV:
            begin
                if (!trial[SUM_W])
                begin
                    rem_next = trial[SUM_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[SUM_W-2:0], quo_reg[SUM_W-1]};
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
                qc_next = qc_reg + QC'(1);
                if (32'(qc_reg) == SUM_W - 1)
                    state_next = gmbs_pkg::ST_COMPARE;
            end
            gmbs_pkg::ST_COMPARE:
            begin
                if (cnt_reg != '0)
                begin
                    if (!have_reg || (mean_full[ERR_W_L-1:0] < best_err_reg) ||
                        ((mean_full[ERR_W_L-1:0] == best_err_reg) && (shift_dist < bd_reg)))
                    begin
                        have_next     = 1'b1;
                        best_err_next = mean_full[ERR_W_L-1:0];
                        bx_next       = dx_reg;
                        by_next       = dy_reg;
                        bd_next       = shift_dist;
                    end
                end
                sum_next = '0;
                cnt_next = '0;
                x_next   = '0;
                y_next   = '0;
                if (last_shift)
                    state_next = gmbs_pkg::ST_OUT;
                else
                begin
                    state_next = gmbs_pkg::ST_SCAN;
                    if (dx_reg == SW'(SEARCH_RANGE))
                    begin
                        dx_next = -SW'(SEARCH_RANGE);
                        dy_next = dy_reg + SW'(1);
                    end
                    else
                        dx_next = dx_reg + SW'(1);
                end
            end
            gmbs_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = gmbs_pkg::ST_LOAD;
            end
            default: state_next = gmbs_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gmbs_pkg::ST_LOAD;
            load_reg  <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            qc_reg    <= '0;
            have_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            load_reg  <= load_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            qc_reg    <= qc_next;
            have_reg  <= have_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        best_err_reg <= best_err_next;
        bx_reg       <= bx_next;
        by_reg       <= by_next;
        bd_reg       <= bd_next;
    end

    assign move_x    = 3'(bx_reg);
    assign move_y    = 3'(by_reg);
    assign min_error = best_err_reg;

    `GMB_ASSERT_IMP(a_ready_only_load, clk, rst_n, in_ready, state_reg == gmbs_pkg::ST_LOAD, "ready outside load")
    `GMB_ASSERT_IMP(a_out_has_best, clk, rst_n, out_valid, have_reg, "result without a candidate")
    `GMB_ASSERT_IMP(a_no_read_idle, clk, rst_n, rv1_reg, $past(state_reg) == gmbs_pkg::ST_SCAN, "read outside scan")
    `GMB_ASSERT_IMP(a_last_restarts, clk, rst_n, accept && last_pixel, ##1 load_reg == '0, "load position not reset")
endmodule
`default_nettype wire
